// ===== rtl/core/swhuc_pkg.sv =====
// ----------------------------------------------------------------------------
// swhuc_pkg: shared constants for the sliding window heavy user counter
// Field widths, register indexes, reset values and default sizes.
// ----------------------------------------------------------------------------
package swhuc_pkg;

   // default sizes
   localparam int FIFO_DEPTH_DEF = 8192;
   localparam int NUM_USERS_DEF  = 1024;

   // field widths
   localparam int USER_W   = 10;
   localparam int TIME_W   = 32;
   localparam int HEAVY_W  = 11;
   localparam int WINDOW_W = 17;
   localparam int THRESH_W = 14;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'b1;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 17'd300;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd5000;

   // command codes
   localparam logic CMD_HIT = 1'b0;

   typedef logic [USER_W+TIME_W-1:0] fifo_entry_type;

endpackage

// ===== rtl/core/sliding_window_heavy_user_counter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_heavy_user_counter: per-user hit counts over a time window
// Steps: S_IDLE takes a beat, S_HEAD tests it, S_EXP_RD retires each expired
// hit, S_HIT_RD counts a queued hit; the result then sits in an output register.
// Throughput is one item at a time, bounded by the read-modify-write loop on
// the user count memory (one read port, one write port).
// After reset a clearing pass zeroes every entry of the user memory
// (NUM_USERS, 1024 by default); no beat is taken until it ends.
// ----------------------------------------------------------------------------
module sliding_window_heavy_user_counter #(
   parameter int FIFO_DEPTH = swhuc_pkg::FIFO_DEPTH_DEF,
   parameter int NUM_USERS  = swhuc_pkg::NUM_USERS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [swhuc_pkg::USER_W-1:0]     req_user_id,
   input  logic [swhuc_pkg::TIME_W-1:0]     req_timestamp,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [swhuc_pkg::HEAVY_W-1:0]    rsp_heavy_users,
   output logic                             rsp_dropped,
   // configuration write port
   input  logic                             csr_we,
   input  logic [swhuc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swhuc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int OCC_W  = $clog2(FIFO_DEPTH + 1);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int UIDX_W = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
   localparam int HT_W   = $clog2(NUM_USERS + 1);
   localparam int UENT_W = CNT_W + 1;

   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [OCC_W-1:0]  OCC_FULL  = OCC_W'(FIFO_DEPTH);
   localparam logic [UIDX_W-1:0] UIDX_LAST = UIDX_W'(NUM_USERS - 1);
   localparam logic [HT_W-1:0]   HT_MAX    = HT_W'(NUM_USERS);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HEAD   = 3'd2;
   localparam logic [2:0] S_EXP_RD = 3'd3;
   localparam logic [2:0] S_HIT_RD = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   // memories
   swhuc_pkg::fifo_entry_type fifo_mem [FIFO_DEPTH];
   logic [UENT_W-1:0]         user_mem [NUM_USERS];

   // control and datapath registers
   logic [2:0]                        state_ff, state_in;
   logic [UIDX_W-1:0]                 clr_ff, clr_in;
   logic [PTR_W-1:0]                  head_ff, head_in;
   logic [PTR_W-1:0]                  tail_ff, tail_in;
   logic [OCC_W-1:0]                  occ_ff, occ_in;
   logic [HT_W-1:0]                   ht_ff, ht_in;
   logic                              drop_ff, drop_in;
   logic                              cmd_ff, cmd_in;
   logic [swhuc_pkg::USER_W-1:0]      user_ff, user_in;
   logic [swhuc_pkg::TIME_W-1:0]      time_ff, time_in;
   logic [swhuc_pkg::WINDOW_W-1:0]    window_ff;
   logic [swhuc_pkg::THRESH_W-1:0]    thresh_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [swhuc_pkg::HEAVY_W-1:0]     rsp_heavy_ff, rsp_heavy_in;
   logic                              rsp_dropped_ff, rsp_dropped_in;
   swhuc_pkg::fifo_entry_type         fifo_rd_ff;
   logic [UENT_W-1:0]                 user_rd_ff;

   // memory ports
   logic                      fifo_we;
   swhuc_pkg::fifo_entry_type fifo_wdata;
   logic                      umem_we;
   logic [UIDX_W-1:0]         umem_waddr;
   logic [UENT_W-1:0]         umem_wdata;
   logic [UIDX_W-1:0]         umem_raddr;

   // decoded values
   logic [swhuc_pkg::USER_W-1:0] head_user;
   logic [swhuc_pkg::TIME_W-1:0] head_time;
   logic [swhuc_pkg::TIME_W-1:0] head_age;
   logic [31:0]                  head_user_ext;
   logic [31:0]                  item_user_ext;
   logic [UIDX_W-1:0]            head_uidx;
   logic [UIDX_W-1:0]            item_uidx;
   logic                         head_expires;
   logic                         item_is_hit;
   logic                         fifo_full;
   logic                         out_free;
   logic [CNT_W-1:0]             rd_cnt;
   logic                         rd_mark;
   logic [CNT_W-1:0]             cnt_dec;
   logic [CNT_W-1:0]             cnt_inc;
   logic                         mark_clear;
   logic                         mark_set;
   logic [PTR_W-1:0]             head_next;
   logic [PTR_W-1:0]             tail_next;

   // split the head entry and the user record
   assign head_user     = fifo_rd_ff[swhuc_pkg::USER_W+swhuc_pkg::TIME_W-1:swhuc_pkg::TIME_W];
   assign head_time     = fifo_rd_ff[swhuc_pkg::TIME_W-1:0];
   assign head_age      = time_ff - head_time;
   assign head_user_ext = 32'(head_user);
   assign item_user_ext = 32'(user_ff);
   assign head_uidx     = head_user_ext[UIDX_W-1:0];
   assign item_uidx     = item_user_ext[UIDX_W-1:0];
   assign rd_cnt        = user_rd_ff[CNT_W-1:0];
   assign rd_mark       = user_rd_ff[CNT_W];

   // expiry test on the oldest queued hit
   assign head_expires = (occ_ff != '0) && (time_ff >= head_time) &&
                         (head_age >= 32'(window_ff));
   assign item_is_hit  = (cmd_ff == swhuc_pkg::CMD_HIT) &&
                         (item_user_ext < 32'(NUM_USERS));
   assign fifo_full    = (occ_ff == OCC_FULL);
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // count update for an expired hit and for a new hit
   assign cnt_dec    = (rd_cnt == '0) ? '0 : rd_cnt - 1'b1;
   assign cnt_inc    = rd_cnt + 1'b1;
   assign mark_clear = rd_mark && (32'(cnt_dec) < 32'(thresh_ff));
   assign mark_set   = !rd_mark && (32'(cnt_inc) >= 32'(thresh_ff));

   // wrap the ring pointers
   assign head_next = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_heavy_users = rsp_heavy_ff;
   assign rsp_dropped     = rsp_dropped_ff;

   // sequencer: expire, then count the hit, then report
   always_comb begin
      logic [31:0] ht_wide;
      state_in       = state_ff;
      clr_in         = clr_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;
      ht_in          = ht_ff;
      drop_in        = drop_ff;
      cmd_in         = cmd_ff;
      user_in        = user_ff;
      time_in        = time_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_heavy_in   = rsp_heavy_ff;
      rsp_dropped_in = rsp_dropped_ff;
      fifo_we        = 1'b0;
      fifo_wdata     = {user_ff, time_ff};
      umem_we        = 1'b0;
      umem_waddr     = item_uidx;
      umem_wdata     = '0;
      umem_raddr     = item_uidx;
      ht_wide        = '0;

      unique case (state_ff)
         S_CLEAR: begin
            umem_we    = 1'b1;
            umem_waddr = clr_ff;
            umem_wdata = '0;
            if (clr_ff == UIDX_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               user_in  = req_user_id;
               time_in  = req_timestamp;
               state_in = S_HEAD;
            end
         end

         S_HEAD: begin
            if (head_expires) begin
               umem_raddr = head_uidx;
               state_in   = S_EXP_RD;
            end else if (item_is_hit && !fifo_full) begin
               umem_raddr = item_uidx;
               state_in   = S_HIT_RD;
            end else begin
               drop_in = item_is_hit;
               if (out_free) begin
                  ht_wide        = 32'(ht_ff);
                  rsp_valid_in   = 1'b1;
                  rsp_heavy_in   = ht_wide[swhuc_pkg::HEAVY_W-1:0];
                  rsp_dropped_in = item_is_hit;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_EXP_RD: begin
            // write back the lowered count, retire the head entry
            umem_we    = 1'b1;
            umem_waddr = head_uidx;
            umem_wdata = {rd_mark && !mark_clear, cnt_dec};
            if (mark_clear && (ht_ff != '0)) begin
               ht_in = ht_ff - 1'b1;
            end
            head_in  = head_next;
            occ_in   = occ_ff - 1'b1;
            state_in = S_HEAD;
         end

         S_HIT_RD: begin
            // count the hit and queue it
            umem_we    = 1'b1;
            umem_waddr = item_uidx;
            umem_wdata = {rd_mark || mark_set, cnt_inc};
            fifo_we    = 1'b1;
            tail_in    = tail_next;
            occ_in     = occ_ff + 1'b1;
            if (mark_set) begin
               ht_in = ht_ff + 1'b1;
            end
            drop_in = 1'b0;
            if (out_free) begin
               ht_wide        = 32'(ht_in);
               rsp_valid_in   = 1'b1;
               rsp_heavy_in   = ht_wide[swhuc_pkg::HEAVY_W-1:0];
               rsp_dropped_in = 1'b0;
               state_in       = S_IDLE;
            end else begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // hold until the output register frees up
            if (out_free) begin
               ht_wide        = 32'(ht_ff);
               rsp_valid_in   = 1'b1;
               rsp_heavy_in   = ht_wide[swhuc_pkg::HEAVY_W-1:0];
               rsp_dropped_in = drop_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         ht_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= swhuc_pkg::WINDOW_RESET;
         thresh_ff    <= swhuc_pkg::THRESH_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         ht_ff        <= ht_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               swhuc_pkg::CSR_WINDOW: begin
                  window_ff <= csr_wdata[swhuc_pkg::WINDOW_W-1:0];
               end
               swhuc_pkg::CSR_THRESHOLD: begin
                  thresh_ff <= csr_wdata[swhuc_pkg::THRESH_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      drop_ff        <= drop_in;
      cmd_ff         <= cmd_in;
      user_ff        <= user_in;
      time_ff        <= time_in;
      rsp_heavy_ff   <= rsp_heavy_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   // hit ring: write at tail, read the upcoming head every cycle
   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[tail_ff] <= fifo_wdata;
      end
      fifo_rd_ff <= fifo_mem[head_in];
   end

   // user record memory: {heavy mark, count}
   always_ff @(posedge clock) begin
      if (umem_we) begin
         user_mem[umem_waddr] <= umem_wdata;
      end
      user_rd_ff <= user_mem[umem_raddr];
   end

   // checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("hit ring occupancy above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty ring with head and tail apart");

   a_hit_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HIT_RD) |=> (occ_ff == OCC_W'($past(occ_ff) + 1'b1)))
      else $error("queued hit did not raise occupancy");

   a_heavy_bound: assert property (@(posedge clock) disable iff (reset)
      ht_ff <= HT_MAX)
      else $error("heavy total above user count");

endmodule

// ===== verif/sliding_window_heavy_user_counter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_heavy_user_counter_tb: self-checking bench for the counter
// Drives hit and query beats through valid/ready, keeps its own copy of the
// hit queue, per-user counts and heavy marks, and checks every response beat
// against it or against a typed-in expectation. A short directed table runs first, then random traffic under
// several idle settings.
// ----------------------------------------------------------------------------
module sliding_window_heavy_user_counter_tb;

   localparam int   FIFO_DEPTH = swhuc_pkg::FIFO_DEPTH_DEF;
   localparam int   NUM_USERS  = swhuc_pkg::NUM_USERS_DEF;
   localparam int   HPTR_W     = $clog2(FIFO_DEPTH);
   localparam logic CMD_QUERY  = ~swhuc_pkg::CMD_HIT;

   typedef struct packed {
      logic [swhuc_pkg::HEAVY_W-1:0] heavy_users;
      logic                          dropped;
   } tally_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [swhuc_pkg::CSR_IDX_W-1:0] index;
      logic                            command;
      logic [swhuc_pkg::USER_W-1:0]    user_id;
      logic [swhuc_pkg::TIME_W-1:0]    value;
      logic                            pinned;
      logic [swhuc_pkg::HEAVY_W-1:0]   heavy_users;
      logic                            dropped;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_valid     = 1'b0;
   logic                             req_ready;
   logic                             req_command   = swhuc_pkg::CMD_HIT;
   logic [swhuc_pkg::USER_W-1:0]     req_user_id   = '0;
   logic [swhuc_pkg::TIME_W-1:0]     req_timestamp = '0;
   logic                             rsp_valid;
   logic                             rsp_ready     = 1'b0;
   logic [swhuc_pkg::HEAVY_W-1:0]    rsp_heavy_users;
   logic                             rsp_dropped;
   logic                             csr_we        = 1'b0;
   logic [swhuc_pkg::CSR_IDX_W-1:0]  csr_index     = swhuc_pkg::CSR_WINDOW;
   logic [swhuc_pkg::CSR_DATA_W-1:0] csr_wdata     = '0;

   // typed-in expectation carried along with a directed beat
   logic                          pin_on      = 1'b0;
   logic [swhuc_pkg::HEAVY_W-1:0] pin_heavy   = '0;
   logic                          pin_dropped = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;

   // shadow of the block state
   logic [swhuc_pkg::WINDOW_W-1:0] window_len = swhuc_pkg::WINDOW_RESET;
   logic [swhuc_pkg::THRESH_W-1:0] heavy_min  = swhuc_pkg::THRESH_RESET;
   logic [swhuc_pkg::TIME_W-1:0]   hit_time [FIFO_DEPTH];
   logic [swhuc_pkg::USER_W-1:0]   hit_user [FIFO_DEPTH];
   logic [HPTR_W-1:0]              hit_head  = '0;
   logic [HPTR_W-1:0]              hit_tail  = '0;
   int unsigned                    hit_count = 0;
   int unsigned                    user_count [NUM_USERS];
   bit                             heavy_mark [NUM_USERS];
   int unsigned                    heavy_sum = 0;

   // expected response beats still outstanding
   tally_type   due_ring [16];
   logic [3:0]  due_wr    = '0;
   logic [3:0]  due_rd    = '0;
   int unsigned due_level = 0;

   row_type plan [22];

   sliding_window_heavy_user_counter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_user_id     (req_user_id),
      .req_timestamp   (req_timestamp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_heavy_users (rsp_heavy_users),
      .rsp_dropped     (rsp_dropped),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // stall the response side at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // advance the shadow state by one beat and return the expected response
   function automatic tally_type tally_item(input logic cmd,
                                            input logic [swhuc_pkg::USER_W-1:0] uid,
                                            input logic [swhuc_pkg::TIME_W-1:0] now);
      tally_type                    res;
      logic [swhuc_pkg::TIME_W-1:0] t;
      logic [swhuc_pkg::USER_W-1:0] u;
      res.dropped = 1'b0;
      // retire queued hits whose age has reached the window
      while (hit_count > 0) begin
         t = hit_time[hit_head];
         u = hit_user[hit_head];
         if (now < t || now - t < swhuc_pkg::TIME_W'(window_len))
            break;
         if (user_count[u] > 0)
            user_count[u]--;
         if (user_count[u] < heavy_min && heavy_mark[u]) begin
            heavy_mark[u] = 1'b0;
            if (heavy_sum > 0)
               heavy_sum--;
         end
         hit_head = hit_head + 1'b1;
         hit_count--;
      end
      // queue and count the hit, or drop it when the queue is full
      if (cmd == swhuc_pkg::CMD_HIT) begin
         if (hit_count >= FIFO_DEPTH) begin
            res.dropped = 1'b1;
         end else begin
            hit_time[hit_tail] = now;
            hit_user[hit_tail] = uid;
            hit_tail = hit_tail + 1'b1;
            hit_count++;
            user_count[uid]++;
            if (user_count[uid] >= heavy_min && !heavy_mark[uid]) begin
               heavy_mark[uid] = 1'b1;
               heavy_sum++;
            end
         end
      end
      res.heavy_users = swhuc_pkg::HEAVY_W'(heavy_sum);
      return res;
   endfunction

   // track register writes, predict accepted beats, check response beats
   always @(posedge clock) begin
      tally_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               swhuc_pkg::CSR_WINDOW:    window_len = csr_wdata[swhuc_pkg::WINDOW_W-1:0];
               swhuc_pkg::CSR_THRESHOLD: heavy_min  = csr_wdata[swhuc_pkg::THRESH_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            want = tally_item(req_command, req_user_id, req_timestamp);
            if (pin_on)
               want = '{pin_heavy, pin_dropped};
            due_ring[due_wr] = want;
            due_wr = due_wr + 1'b1;
            due_level++;
         end
         if (rsp_valid && rsp_ready) begin
            if (due_level == 0) begin
               report_mismatch($sformatf("response beat with none due: heavy_users=%0d",
                                         rsp_heavy_users));
            end else begin
               want = due_ring[due_rd];
               due_rd = due_rd + 1'b1;
               due_level--;
               if (rsp_heavy_users !== want.heavy_users)
                  report_mismatch($sformatf("heavy_users %0d, expected %0d",
                                            rsp_heavy_users, want.heavy_users));
               if (rsp_dropped !== want.dropped)
                  report_mismatch($sformatf("dropped %0b, expected %0b",
                                            rsp_dropped, want.dropped));
            end
         end
      end
   end

   // present one request beat and hold it until taken; entered at a falling edge
   task automatic send_beat(input logic cmd, input logic [swhuc_pkg::USER_W-1:0] uid,
                            input logic [swhuc_pkg::TIME_W-1:0] ts, input logic pinned,
                            input logic [swhuc_pkg::HEAVY_W-1:0] heavy, input logic drop);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_user_id   <= uid;
      req_timestamp <= ts;
      pin_on        <= pinned;
      pin_heavy     <= heavy;
      pin_dropped   <= drop;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [swhuc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [swhuc_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid and wait until every response beat has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (due_level != 0);
      repeat (4) @(negedge clock);
   endtask

   // empty the hit queue: zero window, then a query at the latest time
   task automatic flush_window();
      settle();
      write_reg(swhuc_pkg::CSR_WINDOW, '0);
      send_beat(CMD_QUERY, swhuc_pkg::USER_W'($urandom_range(NUM_USERS - 1)), '1,
                1'b0, '0, 1'b0);
      settle();
   endtask

   function automatic row_type beat(input logic cmd,
                                    input logic [swhuc_pkg::USER_W-1:0] uid,
                                    input logic [swhuc_pkg::TIME_W-1:0] ts,
                                    input logic pinned,
                                    input logic [swhuc_pkg::HEAVY_W-1:0] heavy,
                                    input logic drop);
      return '{ROW_BEAT, swhuc_pkg::CSR_WINDOW, cmd, uid, ts, pinned, heavy, drop};
   endfunction

   function automatic row_type csr_row(input logic [swhuc_pkg::CSR_IDX_W-1:0] idx,
                                       input logic [swhuc_pkg::TIME_W-1:0] data);
      return '{ROW_CSR, idx, CMD_QUERY, '0, data, 1'b0, '0, 1'b0};
   endfunction

   initial begin
      logic [swhuc_pkg::USER_W-1:0] pool [4];
      logic [swhuc_pkg::TIME_W-1:0] now_ts;
      logic [swhuc_pkg::TIME_W-1:0] ts;
      logic [swhuc_pkg::USER_W-1:0] uid;
      logic                         cmd;
      int                           r;
      int                           idle_send [4];
      int                           idle_recv [4];

      idle_send = '{0, 54, 0, 15};
      idle_recv = '{0, 0, 54, 15};

      plan = '{
         // reset settings: nothing can be heavy yet
         beat(CMD_QUERY,          10'd1023, 32'd0, 1'b1, 11'd0, 1'b0),
         beat(swhuc_pkg::CMD_HIT, 10'd0,    32'd0, 1'b1, 11'd0, 1'b0),
         csr_row(swhuc_pkg::CSR_THRESHOLD, 32'd2),
         csr_row(swhuc_pkg::CSR_WINDOW,    32'd10),
         beat(swhuc_pkg::CMD_HIT, 10'd1023, 32'd5,  1'b0, '0, 1'b0),
         beat(swhuc_pkg::CMD_HIT, 10'd1023, 32'd6,  1'b0, '0, 1'b0),
         beat(swhuc_pkg::CMD_HIT, 10'd0,    32'd9,  1'b0, '0, 1'b0),
         // age equal to the window expires
         beat(CMD_QUERY,          10'd0,    32'd10, 1'b0, '0, 1'b0),
         beat(swhuc_pkg::CMD_HIT, 10'd5,    32'hFFFF_FFFF, 1'b0, '0, 1'b0),
         // time going backwards: expiry halts at the later hit
         beat(CMD_QUERY,          10'd0,    32'd3,  1'b0, '0, 1'b0),
         beat(swhuc_pkg::CMD_HIT, 10'd5,    32'd3,  1'b0, '0, 1'b0),
         csr_row(swhuc_pkg::CSR_WINDOW,    32'd0),
         beat(CMD_QUERY,          10'd0,    32'd3,  1'b0, '0, 1'b0),
         beat(CMD_QUERY,          10'd0,    32'hFFFF_FFFF, 1'b0, '0, 1'b0),
         // zero threshold: marks stick through expiry
         csr_row(swhuc_pkg::CSR_THRESHOLD, 32'd0),
         beat(swhuc_pkg::CMD_HIT, 10'd7,    32'hFFFF_FFFF, 1'b0, '0, 1'b0),
         beat(swhuc_pkg::CMD_HIT, 10'h2AA,  32'hFFFF_FFFF, 1'b0, '0, 1'b0),
         beat(CMD_QUERY,          10'h155,  32'hFFFF_FFFF, 1'b0, '0, 1'b0),
         csr_row(swhuc_pkg::CSR_WINDOW,    32'h1_FFFF),
         csr_row(swhuc_pkg::CSR_THRESHOLD, 32'h3FFF),
         beat(swhuc_pkg::CMD_HIT, 10'h155,  32'h8000_0000, 1'b0, '0, 1'b0),
         beat(CMD_QUERY,          10'h2AA,  32'h8000_0000, 1'b0, '0, 1'b0)
      };

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed table
      send_idle_pct  = 15;
      recv_stall_pct = 15;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_reg(plan[i].index, plan[i].value[swhuc_pkg::CSR_DATA_W-1:0]);
         end else begin
            send_beat(plan[i].command, plan[i].user_id, plan[i].value,
                      plan[i].pinned, plan[i].heavy_users, plan[i].dropped);
         end
      end

      // random traffic, two settings per idle phase
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_send[p];
         recv_stall_pct = idle_recv[p];
         for (int half = 0; half < 2; half++) begin
            flush_window();
            case ($urandom_range(9))
               0:       write_reg(swhuc_pkg::CSR_WINDOW, 17'd1);
               1:       write_reg(swhuc_pkg::CSR_WINDOW, 17'd86400);
               default: write_reg(swhuc_pkg::CSR_WINDOW,
                                  swhuc_pkg::CSR_DATA_W'($urandom_range(60, 4)));
            endcase
            case ($urandom_range(9))
               0:       write_reg(swhuc_pkg::CSR_THRESHOLD, 17'd1);
               1:       write_reg(swhuc_pkg::CSR_THRESHOLD, 17'd8192);
               default: write_reg(swhuc_pkg::CSR_THRESHOLD,
                                  swhuc_pkg::CSR_DATA_W'($urandom_range(6, 2)));
            endcase
            foreach (pool[k])
               pool[k] = swhuc_pkg::USER_W'($urandom_range(NUM_USERS - 1));
            now_ts = $urandom_range(32'hFFF0_0000);
            for (int n = 0; n < 80; n++) begin
               r   = $urandom_range(99);
               cmd = ($urandom_range(99) < 20) ? CMD_QUERY : swhuc_pkg::CMD_HIT;
               uid = ($urandom_range(99) < 85)
                        ? pool[2'($urandom_range(3))]
                        : swhuc_pkg::USER_W'($urandom_range(NUM_USERS - 1));
               if (r < 5) begin
                  // stale time stamp
                  ts = now_ts - $urandom_range(20, 1);
               end else begin
                  now_ts = now_ts + ((r < 9) ? $urandom_range(200) : $urandom_range(2));
                  ts = now_ts;
               end
               send_beat(cmd, uid, ts, 1'b0, '0, 1'b0);
            end
         end
      end

      // drain and let any stray beat show up
      settle();
      repeat (16) @(negedge clock);
      if (mismatch_count == 0)
         $display("sliding_window_heavy_user_counter regression: pass");
      else
         $display("sliding_window_heavy_user_counter regression: fail");
      $finish;
   end

   // hard stop if the run hangs
   initial begin
      #(6_000_000);
      $display("sliding_window_heavy_user_counter regression: fail");
      $finish;
   end

endmodule

// ===== sliding_window_heavy_user_counter.f =====
rtl/core/swhuc_pkg.sv
rtl/core/sliding_window_heavy_user_counter.sv
verif/sliding_window_heavy_user_counter_tb.sv
